>>> rtl/swept_box_contact_defines.svh
// Assertion macros shared by the swept box contact RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SWEPT_BOX_CONTACT_DEFINES_SVH
`define SWEPT_BOX_CONTACT_DEFINES_SVH

// a implies b in the same cycle, checked outside reset
`define SWC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");

// a implies b in the next cycle, checked outside reset
`define SWC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

>>> rtl/swc_pkg.sv
// Package for the swept box contact block: widths, face codes, a stage struct.
// No dependencies.
package swc_pkg;

  localparam int PosW  = 24;
  localparam int VelW  = 20;
  localparam int DiffW = PosW + 1;
  localparam int ProdW = DiffW + VelW;
  localparam int FracShift = 16;
  localparam int NumW  = DiffW + FracShift;  // quotient magnitude width
  localparam int TimeW = 24;

  localparam logic [TimeW-1:0] TimeOne = TimeW'(65536);
  localparam logic [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};

  typedef enum logic [2:0] {
    FACE_RIGHT = 3'd0,
    FACE_DOWN  = 3'd1,
    FACE_LEFT  = 3'd2,
    FACE_UP    = 3'd3,
    FACE_NONE  = 3'd4
  } face_t;

  // handed from the face-select front end to the divider pipeline
  typedef struct packed {
    logic              valid;
    logic              overlap;
    face_t             face;
    logic              zero_div;
    logic              neg;
    logic [NumW-1:0]   num;
    logic [VelW-1:0]   den;
  } div_in_t;

endpackage

>>> rtl/swc_if.sv
// Valid/ready channel interfaces for box pairs and contact results.
// Depends on swc_pkg.
interface swc_pair_if import swc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] self_left;
  logic signed [PosW-1:0] self_top;
  logic signed [PosW-1:0] self_right;
  logic signed [PosW-1:0] self_bottom;
  logic signed [PosW-1:0] other_left;
  logic signed [PosW-1:0] other_top;
  logic signed [PosW-1:0] other_right;
  logic signed [PosW-1:0] other_bottom;
  logic signed [VelW-1:0] vel_x;
  logic signed [VelW-1:0] vel_y;
  modport source (output valid, self_left, self_top, self_right, self_bottom,
                  other_left, other_top, other_right, other_bottom, vel_x, vel_y,
                  input ready);
  modport sink (input valid, self_left, self_top, self_right, self_bottom,
                other_left, other_top, other_right, other_bottom, vel_x, vel_y,
                output ready);
endinterface

interface swc_result_if import swc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    boxes_overlap;
  logic [2:0]              contact_face;
  logic signed [TimeW-1:0] contact_time;
  logic                    time_saturated;
  modport source (output valid, boxes_overlap, contact_face, contact_time,
                  time_saturated, input ready);
  modport sink (input valid, boxes_overlap, contact_face, contact_time,
                time_saturated, output ready);
endinterface

>>> rtl/swc_front.sv
// Front end: edge gaps, corner cross product, face choice, divide operands.
// Three register stages. Depends on swc_pkg.
module swc_front import swc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [PosW-1:0] self_left,
  input  logic signed [PosW-1:0] self_top,
  input  logic signed [PosW-1:0] self_right,
  input  logic signed [PosW-1:0] self_bottom,
  input  logic signed [PosW-1:0] other_left,
  input  logic signed [PosW-1:0] other_top,
  input  logic signed [PosW-1:0] other_right,
  input  logic signed [PosW-1:0] other_bottom,
  input  logic signed [VelW-1:0] vel_x,
  input  logic signed [VelW-1:0] vel_y,
  output div_in_t                div_in
);

  // stage 1: gaps picked by velocity sign, overlap
  logic                    s1_valid, s1_overlap;
  logic signed [DiffW-1:0] s1_dx, s1_dy;
  logic signed [VelW-1:0]  s1_vx, s1_vy;

  // stage 2: products and magnitudes
  logic                    s2_valid, s2_overlap;
  logic signed [ProdW-1:0] s2_p1, s2_p2;
  logic [DiffW-1:0]        s2_adx, s2_ady;
  logic [VelW-1:0]         s2_avx, s2_avy;
  logic                    s2_dxn, s2_dyn;
  logic                    s2_vxp, s2_vxn, s2_vyp, s2_vyn;

  logic signed [ProdW:0]   cross_val;
  logic                    cneg, czero;
  face_t                   face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_overlap <= (other_left < self_right) && (self_left < other_right) &&
                    (other_top < self_bottom) && (self_top < other_bottom);
      s1_dx <= vel_x[VelW-1] ? DiffW'(other_right) - DiffW'(self_left)
                             : DiffW'(other_left) - DiffW'(self_right);
      s1_dy <= vel_y[VelW-1] ? DiffW'(other_bottom) - DiffW'(self_top)
                             : DiffW'(other_top) - DiffW'(self_bottom);
      s1_vx <= vel_x;
      s1_vy <= vel_y;

      s2_overlap <= s1_overlap;
      s2_p1  <= ProdW'(s1_dx) * ProdW'(s1_vy);
      s2_p2  <= ProdW'(s1_dy) * ProdW'(s1_vx);
      s2_adx <= s1_dx[DiffW-1] ? DiffW'(-s1_dx) : DiffW'(s1_dx);
      s2_ady <= s1_dy[DiffW-1] ? DiffW'(-s1_dy) : DiffW'(s1_dy);
      s2_avx <= s1_vx[VelW-1] ? VelW'(-s1_vx) : VelW'(s1_vx);
      s2_avy <= s1_vy[VelW-1] ? VelW'(-s1_vy) : VelW'(s1_vy);
      s2_dxn <= s1_dx[DiffW-1];
      s2_dyn <= s1_dy[DiffW-1];
      s2_vxn <= s1_vx[VelW-1];
      s2_vyn <= s1_vy[VelW-1];
      s2_vxp <= !s1_vx[VelW-1] && (s1_vx != '0);
      s2_vyp <= !s1_vy[VelW-1] && (s1_vy != '0);
    end
  end

  always_comb begin
    cross_val = (ProdW+1)'(s2_p1) - (ProdW+1)'(s2_p2);
    cneg  = cross_val[ProdW];
    czero = (cross_val == '0);
    priority if (s2_vxp && s2_vyp) face = cneg ? FACE_DOWN : FACE_RIGHT;
    else if (s2_vxn && s2_vyp)     face = cneg ? FACE_LEFT : FACE_DOWN;
    else if (s2_vxn && s2_vyn)     face = cneg ? FACE_UP : (czero ? FACE_NONE : FACE_LEFT);
    else if (s2_vxp && s2_vyn)     face = (cneg || czero) ? FACE_RIGHT : FACE_UP;
    else if (s2_vxp)               face = FACE_RIGHT;
    else if (s2_vyp)               face = FACE_DOWN;
    else if (s2_vxn)               face = FACE_LEFT;
    else if (s2_vyn)               face = FACE_UP;
    else                           face = FACE_NONE;
  end

  // stage 3: operands of the gap / velocity divide
  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else if (en) begin
      div_in.valid   <= s2_valid;
      div_in.overlap <= s2_overlap;
      div_in.face    <= face;
      if (face == FACE_RIGHT || face == FACE_LEFT) begin
        div_in.num      <= {s2_adx, {FracShift{1'b0}}};
        div_in.den      <= s2_avx;
        div_in.neg      <= s2_dxn ^ s2_vxn;
        div_in.zero_div <= (s2_avx == '0);
      end else begin
        div_in.num      <= {s2_ady, {FracShift{1'b0}}};
        div_in.den      <= s2_avy;
        div_in.neg      <= s2_dyn ^ s2_vyn;
        div_in.zero_div <= (s2_avy == '0);
      end
    end
  end

endmodule

>>> rtl/swc_div.sv
// Pipelined restoring divider, one quotient bit per stage, then sign and clip.
// Depends on swc_pkg.
module swc_div import swc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  div_in_t                 div_in,
  output logic                    out_valid,
  output logic                    out_overlap,
  output logic [2:0]              out_face,
  output logic signed [TimeW-1:0] out_time,
  output logic                    out_sat
);

  // stage k holds the partial remainder and the numerator/quotient shift word
  logic              st_valid [NumW+1];
  logic              st_overlap [NumW+1];
  face_t             st_face [NumW+1];
  logic              st_zero [NumW+1];
  logic              st_neg [NumW+1];
  logic [NumW-1:0]   st_nq [NumW+1];
  logic [VelW-1:0]   st_rem [NumW+1];
  logic [VelW-1:0]   st_den [NumW+1];

  always_comb begin
    st_valid[0]   = div_in.valid;
    st_overlap[0] = div_in.overlap;
    st_face[0]    = div_in.face;
    st_zero[0]    = div_in.zero_div;
    st_neg[0]     = div_in.neg;
    st_nq[0]      = div_in.num;
    st_rem[0]     = '0;
    st_den[0]     = div_in.den;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_step
    logic [VelW:0] trial;
    logic          qbit;
    always_comb begin
      trial = {st_rem[k], st_nq[k][NumW-1]};
      qbit  = (trial >= {1'b0, st_den[k]});
    end
    always_ff @(posedge clk) begin
      if (rst) st_valid[k+1] <= 1'b0;
      else if (en) st_valid[k+1] <= st_valid[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_overlap[k+1] <= st_overlap[k];
        st_face[k+1]    <= st_face[k];
        st_zero[k+1]    <= st_zero[k];
        st_neg[k+1]     <= st_neg[k];
        st_den[k+1]     <= st_den[k];
        st_nq[k+1]      <= {st_nq[k][NumW-2:0], qbit};
        st_rem[k+1]     <= qbit ? VelW'(trial - {1'b0, st_den[k]}) : VelW'(trial);
      end
    end
  end

  logic [NumW-1:0] q;
  assign q = st_nq[NumW];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= st_valid[NumW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_overlap <= st_overlap[NumW];
      out_face    <= st_face[NumW];
      out_sat     <= 1'b0;
      priority if (st_face[NumW] == FACE_NONE) begin
        out_time <= TimeOne;
      end else if (st_zero[NumW]) begin
        out_time <= '0;
      end else if (st_neg[NumW]) begin
        if (q > NumW'(TimeMin)) begin
          out_time <= TimeMin;
          out_sat  <= 1'b1;
        end else begin
          out_time <= TimeW'(-q);
        end
      end else begin
        if (q > NumW'(TimeMax)) begin
          out_time <= TimeMax;
          out_sat  <= 1'b1;
        end else begin
          out_time <= TimeW'(q);
        end
      end
    end
  end

endmodule

>>> rtl/swept_box_contact.sv
// Top level of the swept box contact block: handshake and pipeline stall.
// Depends on swc_pkg, swc_if, swc_front, swc_div, swept_box_contact_defines.svh.
//
//  channel  | dir | transfer payload
//  ---------+-----+---------------------------------------------------
//  pair     | in  | self/other left, top, right, bottom; vel_x, vel_y
//  result   | out | boxes_overlap, contact_face, contact_time, time_saturated
//
// One pair per cycle sustained while the result is not stalled; 3 front-end stages
// (gaps, cross product, face pick), 41 divider stages (one quotient bit
// each) and the clip/output register.
// rst is synchronous; it clears the stage valid bits only.
// A stalled result freezes the whole pipeline; pair.ready falls only then.
`include "swept_box_contact_defines.svh"
module swept_box_contact import swc_pkg::*; (
  input logic          clk,
  input logic          rst,
  swc_pair_if.sink     pair,
  swc_result_if.source result
);

  logic    en;
  div_in_t div_in;

  // advance when the output register is empty or being taken
  assign en = !result.valid || result.ready;
  assign pair.ready = en;

  swc_front u_front (
    .clk, .rst, .en,
    .in_valid     (pair.valid),
    .self_left    (pair.self_left),
    .self_top     (pair.self_top),
    .self_right   (pair.self_right),
    .self_bottom  (pair.self_bottom),
    .other_left   (pair.other_left),
    .other_top    (pair.other_top),
    .other_right  (pair.other_right),
    .other_bottom (pair.other_bottom),
    .vel_x        (pair.vel_x),
    .vel_y        (pair.vel_y),
    .div_in       (div_in)
  );

  swc_div u_div (
    .clk, .rst, .en,
    .div_in      (div_in),
    .out_valid   (result.valid),
    .out_overlap (result.boxes_overlap),
    .out_face    (result.contact_face),
    .out_time    (result.contact_time),
    .out_sat     (result.time_saturated)
  );

  // no face always reads as time 1.0, unclipped
  `SWC_ASSERT_IMPLY(a_none_time, clk, rst,
    result.valid && result.contact_face == FACE_NONE,
    result.contact_time == TimeOne && !result.time_saturated)
  // a clipped time sits on a rail
  `SWC_ASSERT_IMPLY(a_sat_rail, clk, rst,
    result.valid && result.time_saturated,
    result.contact_time == TimeMax || result.contact_time == TimeMin)
  // a held result stays in place
  `SWC_ASSERT_NEXT(a_stall_hold, clk, rst,
    result.valid && !result.ready,
    result.valid && $stable(result.contact_time) && $stable(result.contact_face))

endmodule

>>> tb/swc_checker.sv
// Contact checker: watches the pair and result channels, predicts each contact result.
// Depends on swc_pkg and swc_if.
`timescale 1ns / 100ps
module swc_checker import swc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  swc_pair_if.sink      pair,
  swc_result_if.sink    result,
  output int            error_count,
  output int            pending_count,
  output int            result_count
);

  typedef struct {
    logic                    overlap;
    face_t                   face;
    logic signed [TimeW-1:0] ctime;
    logic                    sat;
  } contact_t;

  contact_t contact_queue[$];

  function automatic contact_t predict_contact(
      longint sl, longint st, longint sr, longint sb,
      longint ol, longint ot, longint orr, longint ob, longint vx, longint vy);
    contact_t r;
    longint c, gap, dv, q;
    r.overlap = (ol < sr && sl < orr && ot < sb && st < ob);
    r.sat = 1'b0;
    if (vx > 0 && vy > 0) begin
      c = (ol - sr) * vy - (ot - sb) * vx;
      r.face = (c < 0) ? FACE_DOWN : FACE_RIGHT;
    end else if (vx < 0 && vy > 0) begin
      c = (orr - sl) * vy - (ot - sb) * vx;
      r.face = (c < 0) ? FACE_LEFT : FACE_DOWN;
    end else if (vx < 0 && vy < 0) begin
      c = (orr - sl) * vy - (ob - st) * vx;
      r.face = (c < 0) ? FACE_UP : ((c == 0) ? FACE_NONE : FACE_LEFT);
    end else if (vx > 0 && vy < 0) begin
      c = (ol - sr) * vy - (ob - st) * vx;
      r.face = (c <= 0) ? FACE_RIGHT : FACE_UP;
    end else if (vx > 0) r.face = FACE_RIGHT;
    else if (vy > 0) r.face = FACE_DOWN;
    else if (vx < 0) r.face = FACE_LEFT;
    else if (vy < 0) r.face = FACE_UP;
    else r.face = FACE_NONE;
    q = 65536;
    if (r.face != FACE_NONE) begin
      case (r.face)
        FACE_RIGHT: begin gap = ol - sr;  dv = vx; end
        FACE_DOWN:  begin gap = ot - sb;  dv = vy; end
        FACE_LEFT:  begin gap = orr - sl; dv = vx; end
        default:    begin gap = ob - st;  dv = vy; end
      endcase
      if (dv != 0) begin
        q = (gap * 65536) / dv;  // SV division truncates toward zero
        if (q > 8388607) begin q = 8388607; r.sat = 1'b1; end
        else if (q < -8388608) begin q = -8388608; r.sat = 1'b1; end
      end else q = 0;
    end
    r.ctime = q[TimeW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    contact_t e;
    if (rst) begin
      error_count  <= 0;
      result_count <= 0;
    end else begin
      if (pair.valid && pair.ready)
        contact_queue.push_back(predict_contact(pair.self_left, pair.self_top,
            pair.self_right, pair.self_bottom, pair.other_left, pair.other_top,
            pair.other_right, pair.other_bottom, pair.vel_x, pair.vel_y));
      if (result.valid && result.ready) begin
        result_count <= result_count + 1;
        if (contact_queue.size() == 0) begin
          $display("%0t: unexpected result transfer", $time);
          error_count <= error_count + 1;
        end else begin
          e = contact_queue.pop_front();
          if (result.boxes_overlap !== e.overlap || result.contact_face !== e.face ||
              result.contact_time !== e.ctime || result.time_saturated !== e.sat) begin
            $display({"%0t: mismatch exp ov=%0b face=%0d t=%0d sat=%0b",
                      " act ov=%0b face=%0d t=%0d sat=%0b"},
                     $time, e.overlap, e.face, e.ctime, e.sat, result.boxes_overlap,
                     result.contact_face, result.contact_time, result.time_saturated);
            error_count <= error_count + 1;
          end
        end
      end
    end
    pending_count <= contact_queue.size();
  end

endmodule

>>> tb/tb_swept_box_contact.sv
// Testbench top for swept_box_contact: clock, reset, pair stimulus and verdict.
// Depends on swc_pkg, swc_if, swc_checker and the block itself.
`timescale 1ns / 100ps
module tb_swept_box_contact;
  import swc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   error_count, pending_count, result_count;
  int   send_idle_pct = 0;   // chance of a gap before each pair
  int   recv_stall_pct = 0;  // chance result.ready is low in a cycle

  always #5 clk = ~clk;

  swc_pair_if   pair ();
  swc_result_if result ();

  swept_box_contact dut (.clk(clk), .rst(rst), .pair(pair), .result(result));

  swc_checker checker_i (.clk(clk), .rst(rst), .pair(pair), .result(result),
                         .error_count(error_count), .pending_count(pending_count),
                         .result_count(result_count));

  // receiver back-pressure, redrawn each cycle; held low in reset
  always @(posedge clk) begin
    result.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop; the slowest run is far below this
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Random edge: extremes a quarter of the time, any value an eighth, otherwise a
  // smallish offset so that boxes actually meet and the quotient stays mostly unclipped.
  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(7))
      0: return {1'b1, {(PosW-1){1'b0}}};
      1: return {1'b0, {(PosW-1){1'b1}}};
      2: return PosW'($urandom);
      default: return PosW'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [VelW-1:0] pick_vel();
    case ($urandom_range(9))
      0: return '0;
      1: return {1'b1, {(VelW-1){1'b0}}};
      2: return {1'b0, {(VelW-1){1'b1}}};
      3: return VelW'($urandom);
      default: return VelW'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // Present one pair and hold it until the transfer; valid is lowered only for
  // idle gaps, so back-to-back transfers keep valid high across edges.
  task automatic send_pair(input logic [PosW-1:0] sl, st, sr, sb, ol, ot, orr, ob,
                           input logic [VelW-1:0] vx, vy);
    while ($urandom_range(99) < send_idle_pct) begin
      pair.valid <= 1'b0;
      @(posedge clk);
    end
    pair.valid <= 1'b1;
    pair.self_left <= sl;  pair.self_top <= st;
    pair.self_right <= sr; pair.self_bottom <= sb;
    pair.other_left <= ol; pair.other_top <= ot;
    pair.other_right <= orr; pair.other_bottom <= ob;
    pair.vel_x <= vx; pair.vel_y <= vy;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
  endtask

  // Random pair: mostly a moving box beside or near the fixed one.
  task automatic send_random();
    logic [PosW-1:0] sl, st, ol, ot;
    if ($urandom_range(3) == 0) begin
      send_pair(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                pick_pos(), pick_pos(), pick_pos(), pick_vel(), pick_vel());
    end else begin
      sl = pick_pos(); st = pick_pos(); ol = pick_pos(); ot = pick_pos();
      send_pair(sl, st, sl + PosW'($urandom_range(2048)), st + PosW'($urandom_range(2048)),
                ol, ot, ol + PosW'($urandom_range(2048)), ot + PosW'($urandom_range(2048)),
                pick_vel(), pick_vel());
    end
  endtask

  localparam logic [PosW-1:0] PMIN = {1'b1, {(PosW-1){1'b0}}};
  localparam logic [PosW-1:0] PMAX = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [VelW-1:0] VMIN = {1'b1, {(VelW-1){1'b0}}};
  localparam logic [VelW-1:0] VMAX = {1'b0, {(VelW-1){1'b1}}};

  initial begin
    int s;
    pair.valid <= 1'b0;
    {pair.self_left, pair.self_top, pair.self_right, pair.self_bottom} <= '0;
    {pair.other_left, pair.other_top, pair.other_right, pair.other_bottom} <= '0;
    pair.vel_x <= '0;
    pair.vel_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: a 256-unit box at the origin, fixed box placed around it.
    // Each quadrant, each single axis, zero velocity.
    send_pair(0, 0, 256, 256, 512, 512, 768, 768, 256, 256);      // down-right tie
    send_pair(0, 0, 256, 256, 512, 300, 768, 768, 256, 256);      // down-right, right
    send_pair(0, 0, 256, 256, -768, 512, -512, 768, -256, 256);   // down-left
    send_pair(0, 0, 256, 256, -768, 512, -512, 768, -256, 100);
    send_pair(0, 0, 256, 256, -512, -512, 0, 0, -256, -256);      // up-left, cross zero: none
    send_pair(0, 0, 256, 256, -768, -512, 0, 0, -256, -256);      // up-left
    send_pair(0, 0, 256, 256, -512, -768, 0, 0, -256, -256);
    send_pair(0, 0, 256, 256, 256, -512, 512, 0, 256, -256);      // up-right tie: right
    send_pair(0, 0, 256, 256, 512, -512, 768, 0, 256, -256);
    send_pair(0, 0, 256, 256, 512, -512, 768, -300, 256, -256);
    send_pair(0, 0, 256, 256, 512, 0, 768, 256, 1, 0);            // axis right
    send_pair(0, 0, 256, 256, 0, 512, 256, 768, 0, 1);            // axis down
    send_pair(0, 0, 256, 256, -512, 0, -256, 256, -1, 0);         // axis left
    send_pair(0, 0, 256, 256, 0, -512, 256, -256, 0, -1);         // axis up
    send_pair(0, 0, 256, 256, 100, 100, 300, 300, 0, 0);          // overlap, no face
    send_pair(256, 256, 0, 0, 100, 100, 300, 300, 3, 5);          // inverted box
    send_pair(PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX, VMAX, VMAX);
    send_pair(PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, PMAX, PMAX, VMIN, VMIN);
    send_pair(PMIN, PMAX, PMAX, PMIN, PMAX, PMIN, PMIN, PMAX, 1, -1);  // saturation
    send_pair(PMAX, PMIN, PMIN, PMAX, PMIN, PMAX, PMAX, PMIN, -1, 1);
    send_pair(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, VMIN, VMAX);

    // Random phases: free running, slow sender, slow receiver, both.
    for (s = 0; s < 4; s++) begin
      case (s)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (375) send_random();
    end
    pair.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d contact results: all quadrants, axis cases, ties, saturation,",
             result_count);
    $display("edge extremes, under sender gaps and receiver stalls.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
